>>> rtl/core/lzwpk_pkg.sv
// Shared constants and types for the LZW code packer.
package lzwpk_pkg;

  localparam int CODE_W = 16;
  localparam int BYTE_W = 8;
  localparam int WIDTH_W = 5;
  localparam int LEFT_W = 7;
  localparam int LCNT_W = 3;
  localparam int GRP_W = 3;
  localparam int GROUP_SIZE = 8;

  localparam logic [WIDTH_W-1:0] WIDTH_MIN = WIDTH_W'(9);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(16);
  localparam logic [GRP_W-1:0] GROUP_LAST = GRP_W'(GROUP_SIZE - 1);

  typedef struct packed {
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic              two;
    logic              ends_group;
    logic [LEFT_W-1:0] left_bits;
    logic [LCNT_W-1:0] left_cnt;
    logic [GRP_W-1:0]  grp_pos;
  } merge_res_t;

endpackage

>>> rtl/core/lzwpk_code_if.sv
// Code input channel: valid/ready with one LZW code.
interface lzwpk_code_if;
  import lzwpk_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_value;
  modport source (output valid, output code_value, input ready);
  modport sink (input valid, input code_value, output ready);
endinterface

>>> rtl/core/lzwpk_byte_if.sv
// Byte output channel: valid/ready with one packed byte and flags.
interface lzwpk_byte_if;
  import lzwpk_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_code;
  logic              group_end;
  modport source (output valid, output out_byte, output last_of_code, output group_end,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_code, input group_end,
                output ready);
endinterface

>>> rtl/core/lzwpk_merge.sv
// Merges one masked code with the leftover bits and splits off complete bytes.
module lzwpk_merge
  import lzwpk_pkg::*;
(
  input  logic [CODE_W-1:0]  code,
  input  logic [WIDTH_W-1:0] width,
  input  logic [LEFT_W-1:0]  left_bits,
  input  logic [LCNT_W-1:0]  left_cnt,
  input  logic [GRP_W-1:0]   grp_pos,
  output merge_res_t         res
);

  localparam int ACC_W = CODE_W + LEFT_W;

  logic [CODE_W-1:0]  code_m;
  logic [ACC_W-1:0]   acc;
  logic [WIDTH_W-1:0] total;
  logic [WIDTH_W-1:0] sh0;
  logic [WIDTH_W-1:0] rem;
  logic               two;
  logic [LEFT_W-1:0]  rem_bits;

  always_comb begin
    code_m   = code & ~({CODE_W{1'b1}} << width);
    acc      = ({{CODE_W{1'b0}}, left_bits} << width) | {{LEFT_W{1'b0}}, code_m};
    total    = {{(WIDTH_W-LCNT_W){1'b0}}, left_cnt} + width;
    two      = total >= WIDTH_W'(2 * BYTE_W);
    sh0      = total - WIDTH_W'(BYTE_W);
    rem      = two ? (total - WIDTH_W'(2 * BYTE_W)) : sh0;
    rem_bits = acc[LEFT_W-1:0] & ~({LEFT_W{1'b1}} << rem[LCNT_W-1:0]);

    res.byte0      = BYTE_W'(acc >> sh0);
    res.byte1      = BYTE_W'(acc >> rem);
    res.two        = two;
    res.ends_group = grp_pos == GROUP_LAST;
    if (res.ends_group) begin
      res.left_bits = '0;
      res.left_cnt  = '0;
      res.grp_pos   = '0;
    end else begin
      res.left_bits = rem_bits;
      res.left_cnt  = rem[LCNT_W-1:0];
      res.grp_pos   = grp_pos + GRP_W'(1);
    end
  end

endmodule

>>> rtl/core/lzw_code_packer_msb.sv
// Top level of the MSB-first LZW code packer.
//
//   channel    dir  payload                               handshake
//   code_in    in   code_value[15:0]                      valid/ready
//   byte_out   out  out_byte[7:0], last_of_code, group_end valid/ready
//   cfg        in   cfg_wdata[4:0] (code_width, 9..16)     cfg_we, no ready
//
// Each code yields one or two output bytes, taken as the byte channel accepts them.
// First byte appears once the code has passed the input register and the byte buffer.
// Synchronous reset clears width to 9, leftover bits, group position and all valids.
// A stalled byte_out holds the byte buffer; code_in keeps taking one code into the
// input register until it is full.
module lzw_code_packer_msb
  import lzwpk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata,
  lzwpk_code_if.sink         code_in,
  lzwpk_byte_if.source       byte_out
);

  logic [WIDTH_W-1:0] width;
  logic [LEFT_W-1:0]  left_bits;
  logic [LCNT_W-1:0]  left_cnt;
  logic [GRP_W-1:0]   grp_pos;

  logic               a_valid;
  logic [CODE_W-1:0]  a_code;

  logic [1:0]         b_cnt;
  logic [1:0]         b_cnt_next;
  logic [BYTE_W-1:0]  b_byte0;
  logic [BYTE_W-1:0]  b_byte1;
  logic               b_ends;

  merge_res_t         res;
  logic               out_fire;
  logic               b_free;
  logic               load;
  logic               in_fire;

  lzwpk_merge u_merge (
    .code      (a_code),
    .width     (width),
    .left_bits (left_bits),
    .left_cnt  (left_cnt),
    .grp_pos   (grp_pos),
    .res       (res)
  );

  assign out_fire      = byte_out.valid && byte_out.ready;
  assign b_free        = (b_cnt == 2'd0) || ((b_cnt == 2'd1) && out_fire);
  assign load          = a_valid && b_free;
  assign code_in.ready = !a_valid || load;
  assign in_fire       = code_in.valid && code_in.ready;

  assign byte_out.valid        = b_cnt != 2'd0;
  assign byte_out.out_byte     = (b_cnt == 2'd2) ? b_byte0 : b_byte1;
  assign byte_out.last_of_code = b_cnt == 2'd1;
  assign byte_out.group_end    = (b_cnt == 2'd1) && b_ends;

  always_comb begin
    if (load) begin
      b_cnt_next = res.two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      b_cnt_next = b_cnt - 2'd1;
    end else begin
      b_cnt_next = b_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= WIDTH_MIN;
      left_bits <= '0;
      left_cnt  <= '0;
      grp_pos   <= '0;
      a_valid   <= 1'b0;
      b_cnt     <= 2'd0;
    end else begin
      if (cfg_we && (cfg_wdata inside {[WIDTH_MIN:WIDTH_MAX]})) begin
        width <= cfg_wdata;
      end
      if (load) begin
        left_bits <= res.left_bits;
        left_cnt  <= res.left_cnt;
        grp_pos   <= res.grp_pos;
      end
      if (in_fire) begin
        a_valid <= 1'b1;
      end else if (load) begin
        a_valid <= 1'b0;
      end
      b_cnt <= b_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_code <= code_in.code_value;
    end
    if (load) begin
      b_byte0 <= res.byte0;
      b_byte1 <= res.two ? res.byte1 : res.byte0;
      b_ends  <= res.ends_group;
    end
  end

endmodule
